// ===== hw/rtl/cbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbcs_pkg: shared types and constants of the cubic Bezier curve sampler
// Operation codes of the shared arithmetic unit, result sources, register
// indexes and the control bundle from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package cbcs_pkg;

	localparam int NB = 6;   // bits of the interval count and the sample index
	localparam int WB = 18;  // bits of a Bernstein weight and of N cubed

	localparam logic [NB-1:0] SPP_RESET  = 6'd62;
	localparam logic [30:0]   ALEN_RESET = 31'd1310720;

	typedef enum logic [0:0] {
		REG_SPP  = 1'b0,
		REG_ALEN = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_MUL  = 3'd1,
		OP_MAC  = 3'd2,
		OP_BIAS = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		OSEL_FIRST  = 2'd0,
		OSEL_SAMPLE = 2'd1,
		OSEL_HELD   = 2'd2,
		OSEL_CLOSE  = 2'd3
	} osel_t;

	typedef struct packed {
		logic          busy;
		logic          cur_we;
		logic          held_we;
		logic [1:0]    held_idx;
		logic          held_src_cur;
		logic [1:0]    rd_idx;
		logic          rd_cur;
		logic          coord_y;
		logic          wgt_s1;
		logic          wgt_s2;
		logic [NB-1:0] j;
		op_t           op;
		logic [1:0]    wsel;
		logic          xsave;
		logic          out_load;
		osel_t         out_sel;
		logic          out_end;
	} ctl_t;

endpackage

// ===== hw/rtl/cbcs_weights.sv =====
// ----------------------------------------------------------------------------
// cbcs_weights: Bernstein weight generator
// Two register stages turn the sample index j and the interval count N into
// the four cubic weights and their sum N^3.
// ----------------------------------------------------------------------------
module cbcs_weights (
	input  logic                        clk,
	input  cbcs_pkg::ctl_t              ctl,
	input  logic [cbcs_pkg::NB-1:0]     n,
	output logic [cbcs_pkg::WB-1:0]     w,
	output logic [cbcs_pkg::WB-1:0]     d
);
	import cbcs_pkg::*;

	logic [NB-1:0]   u;
	logic [NB-1:0]   u_s1, j_s1, n_s1;
	logic [2*NB-1:0] uu_s1, jj_s1, ju_s1, nn_s1;
	logic [WB-1:0]   w_s2 [4];
	logic [WB-1:0]   d_s2;
	logic [WB-1:0]   juu, jju;

	assign u = n - ctl.j;

	always_ff @(posedge clk) begin
		if (ctl.wgt_s1) begin
			u_s1  <= u;
			j_s1  <= ctl.j;
			n_s1  <= n;
			uu_s1 <= (2*NB)'(u) * (2*NB)'(u);
			jj_s1 <= (2*NB)'(ctl.j) * (2*NB)'(ctl.j);
			ju_s1 <= (2*NB)'(ctl.j) * (2*NB)'(u);
			nn_s1 <= (2*NB)'(n) * (2*NB)'(n);
		end
	end

	// The factor of three fits: 3*j*u*u and 3*j*j*u never exceed N^3.
	assign juu = WB'(ju_s1) * WB'(u_s1);
	assign jju = WB'(ju_s1) * WB'(j_s1);

	always_ff @(posedge clk) begin
		if (ctl.wgt_s2) begin
			w_s2[0] <= WB'(uu_s1) * WB'(u_s1);
			w_s2[1] <= juu + {juu[WB-2:0], 1'b0};
			w_s2[2] <= jju + {jju[WB-2:0], 1'b0};
			w_s2[3] <= WB'(jj_s1) * WB'(j_s1);
			d_s2    <= WB'(nn_s1) * WB'(n_s1);
		end
	end

	assign w = w_s2[ctl.wsel];
	assign d = d_s2;

endmodule

// ===== hw/rtl/cbcs_arith.sv =====
// ----------------------------------------------------------------------------
// cbcs_arith: shared multiply-accumulate and restoring divider
// One wide accumulator gathers the weighted sum, is biased to a non-negative
// numerator and is then divided by N^3 one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbcs_arith #(
	parameter int CB = 32
) (
	input  logic                        clk,
	input  cbcs_pkg::op_t               op,
	input  logic [cbcs_pkg::WB-1:0]     w,
	input  logic signed [CB-1:0]        p,
	input  logic [cbcs_pkg::WB-1:0]     d,
	output logic signed [CB-1:0]        q
);
	import cbcs_pkg::*;

	localparam int AW = CB + WB + 1;

	logic [AW-1:0]        acc_q, acc_d;
	logic signed [AW-1:0] prod;
	logic [AW-1:0]        sh;
	logic [WB+1:0]        diff;

	assign prod = $signed({1'b0, w}) * p;
	assign sh   = {acc_q[AW-2:0], 1'b0};
	assign diff = {1'b0, sh[AW-1:CB]} - {2'b00, d};

	always_comb begin
		acc_d = acc_q;
		unique case (op)
			OP_NONE: acc_d = acc_q;
			OP_MUL:  acc_d = prod;
			OP_MAC:  acc_d = acc_q + prod;
			// Rounding half plus an offset of N^3 * 2^(CB-1) makes the numerator
			// non-negative; the quotient then carries the same offset.
			OP_BIAS: acc_d = acc_q + AW'(d >> 1) + (AW'(d) << (CB - 1));
			OP_DIV: begin
				if (!diff[WB+1]) begin
					acc_d = {diff[WB:0], sh[CB-1:1], 1'b1};
				end else begin
					acc_d = sh;
				end
			end
			default: acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
	end

	// Removing the offset of 2^(CB-1) is a flip of the top quotient bit.
	assign q = {~acc_q[CB-1], acc_q[CB-2:0]};

endmodule

// ===== hw/rtl/cbcs_seq.sv =====
// ----------------------------------------------------------------------------
// cbcs_seq: sequencer of the curve sampler
// Tracks the held points of the segment under construction and steps the
// weight generator and the shared arithmetic unit through every sample.
// ----------------------------------------------------------------------------
module cbcs_seq #(
	parameter int CB = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        point_valid,
	input  logic                        final_point,
	input  logic                        emit_ok,
	input  logic [cbcs_pkg::NB-1:0]     n,
	output cbcs_pkg::ctl_t              ctl
);
	import cbcs_pkg::*;

	localparam int SW = $clog2(CB);

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_DISP   = 12'b000000000010,
		ST_FIRST  = 12'b000000000100,
		ST_WGT1   = 12'b000000001000,
		ST_WGT2   = 12'b000000010000,
		ST_MAC    = 12'b000000100000,
		ST_BIAS   = 12'b000001000000,
		ST_DIV    = 12'b000010000000,
		ST_XSAVE  = 12'b000100000000,
		ST_SAMPLE = 12'b001000000000,
		ST_LEFT   = 12'b010000000000,
		ST_CLOSE  = 12'b100000000000
	} state_t;

	state_t        state_q, state_d, after_first;
	logic          started_q, joined_q, first_q, seg_q, fin_q, c_q;
	logic [1:0]    ph_q, lk_q, k_q;
	logic [NB-1:0] j_q;
	logic [SW-1:0] s_q;
	logic          accept, last_j, last_left;

	assign accept    = (state_q == ST_IDLE) && point_valid;
	assign last_j    = (j_q == n);
	assign last_left = ({1'b0, lk_q} + 3'd1) >= {1'b0, ph_q};

	always_comb begin
		if (seg_q) begin
			after_first = ST_WGT1;
		end else if (fin_q) begin
			after_first = (lk_q < ph_q) ? ST_LEFT : ST_CLOSE;
		end else begin
			after_first = ST_IDLE;
		end
	end

	always_comb begin
		state_d          = state_q;
		ctl              = '0;
		ctl.op           = OP_NONE;
		ctl.out_sel      = OSEL_FIRST;
		ctl.busy         = (state_q != ST_IDLE);
		ctl.j            = j_q;
		ctl.wsel         = k_q;
		ctl.rd_idx       = k_q;
		ctl.rd_cur       = (k_q == 2'd3);
		ctl.coord_y      = c_q;
		unique case (state_q)
			ST_IDLE: begin
				if (point_valid) begin
					ctl.cur_we   = 1'b1;
					ctl.held_we  = (ph_q != 2'd3);
					ctl.held_idx = ph_q;
					state_d      = ST_DISP;
				end
			end
			ST_DISP: state_d = first_q ? ST_FIRST : after_first;
			ST_FIRST: begin
				ctl.out_sel = OSEL_FIRST;
				ctl.out_end = !seg_q && !fin_q;
				if (emit_ok) begin
					ctl.out_load = 1'b1;
					state_d      = after_first;
				end
			end
			ST_WGT1: begin
				ctl.wgt_s1 = 1'b1;
				state_d    = ST_WGT2;
			end
			ST_WGT2: begin
				ctl.wgt_s2 = 1'b1;
				state_d    = ST_MAC;
			end
			ST_MAC: begin
				ctl.op = (k_q == 2'd0) ? OP_MUL : OP_MAC;
				if (k_q == 2'd3) begin
					state_d = ST_BIAS;
				end
			end
			ST_BIAS: begin
				ctl.op  = OP_BIAS;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				ctl.op = OP_DIV;
				if (s_q == SW'(CB - 1)) begin
					state_d = c_q ? ST_SAMPLE : ST_XSAVE;
				end
			end
			ST_XSAVE: begin
				ctl.xsave = 1'b1;
				state_d   = ST_MAC;
			end
			ST_SAMPLE: begin
				ctl.out_sel = OSEL_SAMPLE;
				ctl.out_end = !fin_q && last_j;
				if (emit_ok) begin
					ctl.out_load = 1'b1;
					if (last_j) begin
						// The closing point of the segment starts the next one.
						ctl.held_we      = 1'b1;
						ctl.held_idx     = 2'd0;
						ctl.held_src_cur = 1'b1;
						state_d          = fin_q ? ST_CLOSE : ST_IDLE;
					end else begin
						state_d = ST_WGT1;
					end
				end
			end
			ST_LEFT: begin
				ctl.out_sel = OSEL_HELD;
				ctl.rd_idx  = lk_q;
				ctl.rd_cur  = 1'b0;
				if (emit_ok) begin
					ctl.out_load = 1'b1;
					state_d      = last_left ? ST_CLOSE : ST_LEFT;
				end
			end
			ST_CLOSE: begin
				ctl.out_sel = OSEL_CLOSE;
				ctl.out_end = 1'b1;
				if (emit_ok) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
			joined_q  <= 1'b0;
			ph_q      <= 2'd0;
			first_q   <= 1'b0;
			seg_q     <= 1'b0;
			fin_q     <= 1'b0;
			lk_q      <= 2'd0;
			k_q       <= 2'd0;
			c_q       <= 1'b0;
			j_q       <= '0;
			s_q       <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				first_q   <= !started_q;
				started_q <= 1'b1;
				seg_q     <= (ph_q == 2'd3);
				fin_q     <= final_point;
				lk_q      <= {1'b0, joined_q};
				j_q       <= '0;
				if (ph_q != 2'd3) begin
					ph_q <= ph_q + 2'd1;
				end
			end
			if (state_q == ST_WGT2 || state_q == ST_XSAVE) begin
				k_q <= 2'd0;
			end
			if (state_q == ST_WGT2) begin
				c_q <= 1'b0;
			end
			if (state_q == ST_XSAVE) begin
				c_q <= 1'b1;
			end
			if (state_q == ST_MAC) begin
				k_q <= k_q + 2'd1;
			end
			if (state_q == ST_BIAS) begin
				s_q <= '0;
			end
			if (state_q == ST_DIV) begin
				s_q <= s_q + SW'(1);
			end
			if (state_q == ST_SAMPLE && emit_ok) begin
				if (last_j) begin
					ph_q     <= 2'd1;
					joined_q <= 1'b1;
				end else begin
					j_q <= j_q + NB'(1);
				end
			end
			if (state_q == ST_LEFT && emit_ok) begin
				lk_q <= lk_q + 2'd1;
			end
			if (state_q == ST_CLOSE && emit_ok) begin
				started_q <= 1'b0;
				joined_q  <= 1'b0;
				ph_q      <= 2'd0;
			end
		end
	end

endmodule

// ===== hw/rtl/cubic_bezier_curve_sampler_core.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_curve_sampler_core: cubic Bezier curve sampler
// A point that emits no Bezier sample passes the dispatch state before its
// first result is loaded; each Bezier sample runs the weight stages, then per
// coordinate the shared multiply-accumulate and one-bit-per-cycle divider, so a
// segment-completing point runs N+1 such samples.
// One item is in work at a time; the next is taken once the last result of
// the previous one is in the output register. Reset loads the register
// defaults and clears the curve state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module cubic_bezier_curve_sampler_core #(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         point_valid,
	output logic                         point_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         final_point,
	output logic                         curve_valid,
	input  logic                         curve_stall,
	output logic signed [31:0]           curve_x,
	output logic signed [31:0]           curve_y,
	output logic                         run_end
);
	import cbcs_pkg::*;

	localparam int CB = COORD_BITS;

	ctl_t                 ctl;
	logic [NB-1:0]        spp_q, n;
	logic [30:0]          alen_q;
	logic                 cfg_we, emit_ok;
	logic signed [CB-1:0] held_x_q [3];
	logic signed [CB-1:0] held_y_q [3];
	logic signed [CB-1:0] cur_x_q, cur_y_q, rx_q;
	logic signed [CB-1:0] hx, hy, pt_x, pt_y, pt, q;
	logic [WB-1:0]        w_sel, d;
	logic                 curve_valid_q;
	logic [31:0]          curve_x_q, curve_y_q;
	logic                 run_end_q;
	logic [31:0]          ox, oy;

	function automatic logic [31:0] sat32(input logic signed [CB-1:0] v);
		logic signed [63:0] ext;
		ext = 64'(v);
		if (ext > 64'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (ext < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return ext[31:0];
	endfunction

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q  <= SPP_RESET;
			alen_q <= ALEN_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_SPP:  spp_q  <= pwdata[NB-1:0];
				REG_ALEN: alen_q <= pwdata[30:0];
				default:  spp_q  <= spp_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_SPP:  prdata = {{(32-NB){1'b0}}, spp_q};
			REG_ALEN: prdata = {1'b0, alen_q};
			default:  prdata = '0;
		endcase
	end

	// An interval count of zero behaves as one.
	assign n = (spp_q == '0) ? NB'(1) : spp_q;

	assign emit_ok     = !curve_valid_q || !curve_stall;
	assign point_stall = ctl.busy;

	cbcs_seq #(.CB(CB)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.final_point (final_point),
		.emit_ok     (emit_ok),
		.n           (n),
		.ctl         (ctl)
	);

	cbcs_weights u_weights (
		.clk (clk),
		.ctl (ctl),
		.n   (n),
		.w   (w_sel),
		.d   (d)
	);

	// Held control points and the point of the item in work.
	always_ff @(posedge clk) begin
		if (ctl.cur_we) begin
			cur_x_q <= point_x;
			cur_y_q <= point_y;
		end
		if (ctl.held_we) begin
			held_x_q[ctl.held_idx] <= ctl.held_src_cur ? cur_x_q : point_x;
			held_y_q[ctl.held_idx] <= ctl.held_src_cur ? cur_y_q : point_y;
		end
		if (ctl.xsave) begin
			rx_q <= q;
		end
	end

	assign hx   = held_x_q[ctl.rd_idx];
	assign hy   = held_y_q[ctl.rd_idx];
	assign pt_x = ctl.rd_cur ? cur_x_q : hx;
	assign pt_y = ctl.rd_cur ? cur_y_q : hy;
	assign pt   = ctl.coord_y ? pt_y : pt_x;

	cbcs_arith #(.CB(CB)) u_arith (
		.clk (clk),
		.op  (ctl.op),
		.w   (w_sel),
		.p   (pt),
		.d   (d),
		.q   (q)
	);

	// Result register.
	always_comb begin
		unique case (ctl.out_sel)
			OSEL_FIRST: begin
				ox = '0;
				oy = sat32(cur_y_q);
			end
			OSEL_SAMPLE: begin
				ox = sat32(rx_q);
				oy = sat32(q);
			end
			OSEL_HELD: begin
				ox = sat32(hx);
				oy = sat32(hy);
			end
			OSEL_CLOSE: begin
				ox = {1'b0, alen_q};
				oy = sat32(cur_y_q);
			end
			default: begin
				ox = '0;
				oy = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			curve_valid_q <= 1'b1;
		end else if (!curve_stall) begin
			curve_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			curve_x_q <= ox;
			curve_y_q <= oy;
			run_end_q <= ctl.out_end;
		end
	end

	assign curve_valid = curve_valid_q;
	assign curve_x     = curve_x_q;
	assign curve_y     = curve_y_q;
	assign run_end     = run_end_q;

endmodule

// ===== sim/cubic_bezier_curve_sampler_core_test.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_curve_sampler_core_test: self-checking bench of the curve sampler
// A short table of directed control points opens the run and walks through
// field extremes, short curves, joined segments and the register corners.
// Random curves follow, mostly whole segments with random coordinates.
// A behavioral predictor tracks the held points and the register values and
// computes every curve point; each output item is checked against it in order,
// or against the typed results of a directed row that carries them.
module cubic_bezier_curve_sampler_core_test;
	import cbcs_pkg::*;

	localparam int RANDOM_POINTS = 260;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic        last;
	} curve_pt_t;

	typedef enum logic {
		ROW_POINT  = 1'b0,
		ROW_CONFIG = 1'b1
	} row_kind_t;

	// A point row may carry up to three typed results; known marks that they
	// replace the predicted ones. A config row carries the two register words.
	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] a;
		logic [31:0] b;
		logic        fin;
		logic        known;
		logic [1:0]  n_known;
		curve_pt_t   k0;
		curve_pt_t   k1;
		curve_pt_t   k2;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               point_valid;
	logic               point_stall;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic               final_point;
	logic               curve_valid;
	logic               curve_stall;
	logic signed [31:0] curve_x;
	logic signed [31:0] curve_y;
	logic               run_end;

	cubic_bezier_curve_sampler_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.final_point (final_point),
		.curve_valid (curve_valid),
		.curve_stall (curve_stall),
		.curve_x     (curve_x),
		.curve_y     (curve_y),
		.run_end     (run_end)
	);

	// Predictor state: register copies and the curve being built.
	logic [5:0]         spp_cfg;
	logic [30:0]        alen_cfg;
	logic signed [31:0] held_x [3];
	logic signed [31:0] held_y [3];
	int                 held_count;
	bit                 curve_started;
	bit                 curve_joined;

	curve_pt_t step_out [$];
	curve_pt_t curve_expected [$];
	stim_row_t directed_rows [$];
	curve_pt_t want;

	int  errors;
	int  items_sent;
	int  curves_sent;
	int  settings_made;
	int  points_checked;
	bit  steady_feed;
	bit  hold_off_req;
	bit  hold_off_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic void add_result(input longint cx, input longint cy);
		if (cx > 64'sd2147483647) cx = 64'sd2147483647;
		if (cx < -64'sd2147483648) cx = -64'sd2147483648;
		if (cy > 64'sd2147483647) cy = 64'sd2147483647;
		if (cy < -64'sd2147483648) cy = -64'sd2147483648;
		step_out.insert(step_out.size(), {cx[31:0], cy[31:0], 1'b0});
	endfunction

	// Nearest value of s/d with ties upward. The offset keeps the dividend
	// positive so that the integer division is a floor.
	function automatic longint round_mix(input longint s, input longint d);
		longint offset;
		offset = longint'(1) << 33;
		return (s + d * offset + d / 2) / d - offset;
	endfunction

	function automatic void clear_curve();
		for (int k = 0; k < 3; k++) begin
			held_x[k] = '0;
			held_y[k] = '0;
		end
		held_count = 0;
		curve_started = 1'b0;
		curve_joined = 1'b0;
	endfunction

	// Fills step_out with the curve points that one control point causes.
	task automatic predict_point(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic fin);
		longint n, d, u, j, sx, sy;
		longint wt [4];
		longint cx [4];
		longint cy [4];
		int k;
		step_out.delete();
		if (!curve_started) begin
			add_result(0, py);
			curve_started = 1'b1;
		end
		if (held_count >= 3) begin
			n = (spp_cfg == 6'd0) ? 1 : longint'(spp_cfg);
			d = n * n * n;
			for (k = 0; k < 3; k++) begin
				cx[k] = held_x[k];
				cy[k] = held_y[k];
			end
			cx[3] = px;
			cy[3] = py;
			for (j = 0; j <= n; j++) begin
				u = n - j;
				wt[0] = u * u * u;
				wt[1] = 3 * j * u * u;
				wt[2] = 3 * j * j * u;
				wt[3] = j * j * j;
				sx = 0;
				sy = 0;
				for (k = 0; k < 4; k++) begin
					sx += wt[k] * cx[k];
					sy += wt[k] * cy[k];
				end
				add_result(round_mix(sx, d), round_mix(sy, d));
			end
			held_x[0] = px;
			held_y[0] = py;
			held_x[1] = '0;
			held_y[1] = '0;
			held_x[2] = '0;
			held_y[2] = '0;
			held_count = 1;
			curve_joined = 1'b1;
		end else begin
			held_x[held_count] = px;
			held_y[held_count] = py;
			held_count++;
		end
		if (fin) begin
			// A shared end point was already sent by its segment.
			for (k = curve_joined ? 1 : 0; k < held_count && k < 3; k++)
				add_result(held_x[k], held_y[k]);
			add_result(longint'(alen_cfg), py);
			clear_curve();
		end
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].last = 1'b1;
	endtask

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_point(input logic [31:0] px, input logic [31:0] py, input logic fin);
		int gap;
		gap = steady_feed ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			point_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		point_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		final_point <= fin;
		do @(posedge clk); while (point_stall);
		items_sent++;
	endtask

	task automatic program_reg(input reg_idx_t idx, input logic [31:0] word);
		logic [31:0] mask;
		logic [31:0] got;
		mask = (idx == REG_SPP) ? 32'h0000_003F : 32'h7FFF_FFFF;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_SPP)
			spp_cfg = word[5:0];
		else
			alen_cfg = word[30:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if ((got & mask) !== (word & mask)) begin
			$error("register %s read back: expected %h, actual %h", idx.name(),
				word & mask, got & mask);
			errors++;
		end
	endtask

	// Registers change only once the block has delivered everything owed.
	task automatic apply_settings(input logic [31:0] spp_word, input logic [31:0] alen_word);
		@(negedge clk);
		point_valid <= 1'b0;
		while (curve_expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		program_reg(REG_SPP, spp_word);
		program_reg(REG_ALEN, alen_word);
		settings_made++;
	endtask

	function automatic logic [31:0] rand_coord();
		int unsigned r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom;
		if (r < 85) begin
			v = int'($urandom_range(0, 2097151)) - 1048576;
			return v;
		end
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [5:0] rand_intervals();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 6'($urandom_range(1, 4));
		if (r < 75) return 6'($urandom_range(5, 12));
		if (r < 85) return 6'd0;
		if (r < 92) return 6'($urandom_range(60, 62));
		return 6'($urandom_range(13, 20));
	endfunction

	function automatic logic [31:0] rand_length_word();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15) return {$urandom_range(0, 1) == 1, 31'd0};
		if (r < 30) return {$urandom_range(0, 1) == 1, 31'h7FFF_FFFF};
		return $urandom;
	endfunction

	function automatic void add_point(input logic [31:0] a, input logic [31:0] b,
			input logic fin);
		directed_rows.insert(directed_rows.size(),
			{ROW_POINT, a, b, fin, 1'b0, 2'd0, 65'd0, 65'd0, 65'd0});
	endfunction

	function automatic void add_known(input logic [31:0] a, input logic [31:0] b,
			input logic fin, input logic [1:0] n, input curve_pt_t k0,
			input curve_pt_t k1, input curve_pt_t k2);
		directed_rows.insert(directed_rows.size(),
			{ROW_POINT, a, b, fin, 1'b1, n, k0, k1, k2});
	endfunction

	function automatic void add_config(input logic [31:0] spp_word,
			input logic [31:0] alen_word);
		directed_rows.insert(directed_rows.size(),
			{ROW_CONFIG, spp_word, alen_word, 1'b0, 1'b0, 2'd0, 65'd0, 65'd0, 65'd0});
	endfunction

	always @(posedge clk) begin
		if (arst_n && curve_valid && !curve_stall) begin
			if (curve_expected.size() == 0) begin
				$error("curve item with nothing expected: x=%h y=%h run_end=%b",
					curve_x, curve_y, run_end);
				errors++;
			end else begin
				want = curve_expected.pop_front();
				points_checked++;
				if (curve_x !== want.x) begin
					$error("curve_x: expected %h, actual %h", want.x, curve_x);
					errors++;
				end
				if (curve_y !== want.y) begin
					$error("curve_y: expected %h, actual %h", want.y, curve_y);
					errors++;
				end
				if (run_end !== want.last) begin
					$error("run_end: expected %b, actual %b", want.last, run_end);
					errors++;
				end
			end
		end
	end

	initial begin : receiver_pace
		int unsigned r;
		int len;
		logic hold;
		curve_stall <= 1'b0;
		forever begin
			if (hold_off_req && !hold_off_done) begin
				// Long hold-off so that the input side backs up.
				@(negedge clk);
				curve_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_off_done = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					hold = 1'b0;
					len = $urandom_range(50, 150);
				end else if (r < 65) begin
					hold = 1'b0;
					len = $urandom_range(1, 4);
				end else if (r < 95) begin
					hold = 1'b1;
					len = $urandom_range(1, 3);
				end else begin
					hold = 1'b1;
					len = $urandom_range(20, 60);
				end
				@(negedge clk);
				curve_stall <= hold;
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		stim_row_t row;
		int random_start;
		int len;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		point_valid <= 1'b0;
		point_x <= '0;
		point_y <= '0;
		final_point <= 1'b0;
		errors = 0;
		items_sent = 0;
		curves_sent = 0;
		settings_made = 0;
		points_checked = 0;
		steady_feed = 1'b0;
		hold_off_req = 1'b0;
		hold_off_done = 1'b0;
		spp_cfg = SPP_RESET;
		alen_cfg = ALEN_RESET;
		clear_curve();

		// Reset values: 62 intervals, closing x of 20.0.
		add_known(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 2'd3,
			{32'h0000_0000, 32'h8000_0000, 1'b0},
			{32'h7FFF_FFFF, 32'h8000_0000, 1'b0},
			{32'h0014_0000, 32'h8000_0000, 1'b1});
		add_known(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 2'd3,
			{32'h0000_0000, 32'h7FFF_FFFF, 1'b0},
			{32'h8000_0000, 32'h7FFF_FFFF, 1'b0},
			{32'h0014_0000, 32'h7FFF_FFFF, 1'b1});
		add_known(32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 2'd1,
			{32'h0000_0000, 32'hFFFF_FFFF, 1'b1}, 65'd0, 65'd0);
		add_known(32'h0000_0000, 32'h0000_0000, 1'b0, 2'd0, 65'd0, 65'd0, 65'd0);
		add_known(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 2'd0, 65'd0, 65'd0, 65'd0);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		add_known(32'h8000_0000, 32'h8000_0000, 1'b0, 2'd0, 65'd0, 65'd0, 65'd0);
		// The shared end point is not sent again with the leftovers.
		add_known(32'h0001_0000, 32'h0002_0000, 1'b1, 2'd3,
			{32'h8000_0000, 32'h8000_0000, 1'b0},
			{32'h0001_0000, 32'h0002_0000, 1'b0},
			{32'h0014_0000, 32'h0002_0000, 1'b1});
		// Zero intervals act as one; closing x at zero.
		add_config(32'd0, 32'd0);
		add_known(32'h0003_0000, 32'h0005_0000, 1'b0, 2'd1,
			{32'h0000_0000, 32'h0005_0000, 1'b1}, 65'd0, 65'd0);
		add_known(32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1, 2'd3,
			{32'h0003_0000, 32'h0005_0000, 1'b0},
			{32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0},
			{32'h0000_0000, 32'h7FFF_FFFF, 1'b1});
		add_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		add_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		add_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		add_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		// Interval count of 62 and the largest closing x.
		add_config(32'd62, 32'h7FFF_FFFF);
		add_known(32'h0000_0001, 32'h0000_0002, 1'b0, 2'd1,
			{32'h0000_0000, 32'h0000_0002, 1'b1}, 65'd0, 65'd0);
		add_known(32'h0000_0003, 32'h0000_0004, 1'b0, 2'd0, 65'd0, 65'd0, 65'd0);
		add_point(32'h0000_0005, 32'h0000_0006, 1'b1);
		add_point(32'h4000_0000, 32'hC000_0000, 1'b0);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		add_point(32'h8000_0000, 32'h8000_0000, 1'b0);
		add_point(32'h0000_0000, 32'h3FFF_FFFF, 1'b1);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < directed_rows.size(); r++) begin
			row = directed_rows[r];
			if (row.kind == ROW_CONFIG) begin
				apply_settings(row.a, row.b);
			end else begin
				send_point(row.a, row.b, row.fin);
				predict_point(row.a, row.b, row.fin);
				if (row.known) begin
					if (row.n_known > 2'd0)
						curve_expected.insert(curve_expected.size(), row.k0);
					if (row.n_known > 2'd1)
						curve_expected.insert(curve_expected.size(), row.k1);
					if (row.n_known > 2'd2)
						curve_expected.insert(curve_expected.size(), row.k2);
				end else begin
					foreach (step_out[i])
						curve_expected.insert(curve_expected.size(), step_out[i]);
				end
				if (row.fin) curves_sent++;
			end
		end

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_POINTS) begin
			if (items_sent == random_start || $urandom_range(0, 3) == 0)
				apply_settings({26'($urandom), rand_intervals()}, rand_length_word());
			steady_feed = ($urandom_range(0, 6) == 0);
			if ($urandom_range(0, 99) < 70)
				len = 3 * $urandom_range(1, 3) + 1;
			else
				len = $urandom_range(1, 9);
			if (curves_sent == 30) hold_off_req = 1'b1;
			for (int p = 0; p < len; p++) begin
				row.a = rand_coord();
				row.b = rand_coord();
				row.fin = (p == len - 1);
				send_point(row.a, row.b, row.fin);
				predict_point(row.a, row.b, row.fin);
				foreach (step_out[i])
					curve_expected.insert(curve_expected.size(), step_out[i]);
			end
			curves_sent++;
		end

		@(negedge clk);
		point_valid <= 1'b0;
		while (curve_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d control points in %0d curves under %0d register settings.",
			items_sent, curves_sent, settings_made + 1);
		$display("Checked %0d curve points against the predicted Bezier samples.",
			points_checked);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
